// ===== rtl/core/ole2_header_validator_core_macros.svh =====
// assertion macros used by the compound-file header validator checker
`ifndef OLE2_HEADER_VALIDATOR_CORE_MACROS_SVH
`define OLE2_HEADER_VALIDATOR_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define OHV_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define OHV_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ohv_pkg.sv =====
// shared types, constants and helpers for the compound-file header validator
`default_nettype none

package ohv_pkg;

  localparam int LEN_W      = 40;
  localparam int OFF_W      = 7;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  localparam logic [OFF_W-1:0] OFF_SAT     = 7'd127;
  localparam logic [OFF_W-1:0] HEADER_NEED = 7'd60;
  localparam logic [OFF_W-1:0] FILE_NEED   = 7'd48;

  localparam logic [15:0] BOM_WORD      = 16'hFFFE;
  localparam logic [31:0] NO_SECTOR     = 32'hFFFFFFFF;
  localparam logic [15:0] EXP_SMALL     = 16'd9;
  localparam logic [15:0] EXP_LARGE     = 16'd12;
  localparam logic [15:0] MINI_EXP      = 16'd6;
  localparam logic [LEN_W-1:0] HDR_SIZE = LEN_W'(512);

  typedef enum logic [1:0] {
    VERDICT_REJECT   = 2'd0,
    VERDICT_STRUCT   = 2'd1,
    VERDICT_VERIFIED = 2'd2
  } verdict_t;

  // header fields gathered from the leading bytes of one stream
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic             sig_ok;
    logic [15:0]      order_mark;
    logic [15:0]      sector_exp;
    logic [15:0]      mini_exp;
    logic [31:0]      fat_count;
    logic [31:0]      dir_start;
    logic [31:0]      cutoff;
  } hdr_fields_t;

  localparam hdr_fields_t FIELDS_CLEAR = '{
    offset: '0, sig_ok: 1'b1, order_mark: '0, sector_exp: '0,
    mini_exp: '0, fat_count: '0, dir_start: '0, cutoff: '0
  };

  // expected signature byte at offsets 0..7
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] m;
    unique case (idx)
      3'd0:    m = 8'hD0;
      3'd1:    m = 8'hCF;
      3'd2:    m = 8'h11;
      3'd3:    m = 8'hE0;
      3'd4:    m = 8'hA1;
      3'd5:    m = 8'hB1;
      3'd6:    m = 8'h1A;
      default: m = 8'hE1;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ohv_capture.sv =====
// byte counter and header field capture registers
`default_nettype none

module ohv_capture (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic                last,
  input  wire logic [7:0]          byte_value,
  output ohv_pkg::hdr_fields_t     fields_next
);
  import ohv_pkg::*;

  hdr_fields_t fields;

  always_comb begin
    fields_next = fields;
    if (fields.offset != OFF_SAT) begin
      fields_next.offset = fields.offset + 1'b1;
      case (fields.offset) inside
        [7'd0:7'd7]: begin
          if (byte_value != magic_byte(fields.offset[2:0])) fields_next.sig_ok = 1'b0;
        end
        [7'd28:7'd29]: fields_next.order_mark[{fields.offset[0], 3'b000} +: 8] = byte_value;
        [7'd30:7'd31]: fields_next.sector_exp[{fields.offset[0], 3'b000} +: 8] = byte_value;
        [7'd32:7'd33]: fields_next.mini_exp[{fields.offset[0], 3'b000} +: 8] = byte_value;
        [7'd44:7'd47]: fields_next.fat_count[{fields.offset[1:0], 3'b000} +: 8] = byte_value;
        [7'd48:7'd51]: fields_next.dir_start[{fields.offset[1:0], 3'b000} +: 8] = byte_value;
        [7'd56:7'd59]: fields_next.cutoff[{fields.offset[1:0], 3'b000} +: 8] = byte_value;
        default: ;
      endcase
    end
  end

  // clear after the last byte of a stream
  always_ff @(posedge clk) begin
    if (rst) begin
      fields <= FIELDS_CLEAR;
    end else if (step) begin
      fields <= last ? FIELDS_CLEAR : fields_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ohv_judge.sv =====
// verdict and size logic for header and file checks
`default_nettype none

module ohv_judge (
  input  wire ohv_pkg::hdr_fields_t        fields,
  input  wire logic [ohv_pkg::LEN_W-1:0]   file_length,
  input  wire logic                        check_phase,
  output ohv_pkg::verdict_t                verdict,
  output logic [ohv_pkg::LEN_W-1:0]        file_size
);
  import ohv_pkg::*;

  logic            len_ok;
  logic            common_ok;
  logic            header_ok;
  logic            exp_in_range;
  logic [3:0]      exp;
  logic [LEN_W-1:0] tail;
  logic [LEN_W-1:0] whole;
  logic [31:0]     product;

  always_comb begin
    len_ok    = |file_length[LEN_W-1:9];
    common_ok = len_ok && fields.sig_ok && (fields.order_mark == BOM_WORD);
    header_ok = common_ok && (fields.offset >= HEADER_NEED)
             && (fields.sector_exp == EXP_SMALL || fields.sector_exp == EXP_LARGE)
             && (fields.mini_exp == MINI_EXP) && (fields.fat_count != '0)
             && (fields.dir_start != NO_SECTOR) && (fields.cutoff != '0);
    exp_in_range = (fields.sector_exp >= EXP_SMALL) && (fields.sector_exp <= EXP_LARGE);
    exp     = fields.sector_exp[3:0];
    // whole sectors following the header, as a byte count
    tail    = file_length - HDR_SIZE;
    whole   = tail & ({LEN_W{1'b1}} << exp);
    product = fields.fat_count << (exp - 4'd2);

    verdict   = VERDICT_REJECT;
    file_size = '0;
    if (!check_phase) begin
      if (header_ok) verdict = VERDICT_STRUCT;
    end else if (common_ok && (fields.offset >= FILE_NEED) && exp_in_range) begin
      if (whole == '0) begin
        verdict = VERDICT_STRUCT;
      end else begin
        file_size = whole + HDR_SIZE;
        verdict   = (product == '0) ? VERDICT_STRUCT : VERDICT_VERIFIED;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ole2_header_validator_core.sv =====
// top level of the compound-file header validator
// The block takes the leading bytes of a candidate compound file, one byte per
// transfer on the slave stream, with the total file length riding along, and
// gives one verdict transfer on the master stream after each byte marked by
// tlast. cfg_wdata selects the check: 0 validates the header fields (signature,
// byte-order mark, sector and mini-sector exponents, FAT count, directory
// start, mini-stream cutoff) and reports size 0; 1 re-checks signature,
// byte-order mark and sector exponent and reports the length rounded down to
// whole sectors past the 512-byte header. Throughput is one byte per cycle,
// set by the single capture register set that every byte steps through, as
// long as the last byte finds the result slot free; the byte is judged out of
// the input register, and m_tvalid rises when the result register loads the
// verdict of the last byte. A verdict held by a low m_tready stalls the input
// only once another last byte reaches the input register. Bytes beyond offset
// 126 are ignored, and the capture state clears itself after every last byte.
// Write the mode only while no stream is in flight.
`default_nettype none

module ole2_header_validator_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration: check_phase
  input  wire logic                            cfg_wen,
  input  wire logic                            cfg_wdata,
  // input stream, tdata: byte_value [7:0], file_length [47:8]
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [ohv_pkg::IN_DATA_W-1:0]   s_tdata,
  input  wire logic                            s_tlast,
  // result stream, tdata: verdict [1:0], file_size [41:2], zero pad [47:42]
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [ohv_pkg::OUT_DATA_W-1:0]       m_tdata
);
  import ohv_pkg::*;

  // mode register
  logic check_phase;

  // input register stage
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic [LEN_W-1:0] s1_len;
  logic             s1_last;
  logic             s1_adv;

  // result register
  logic             out_valid;
  verdict_t         out_verdict;
  logic [LEN_W-1:0] out_size;

  hdr_fields_t      fields_next;
  verdict_t         verdict;
  logic [LEN_W-1:0] file_size;

  // a byte that is not last never needs the result slot
  assign s1_adv   = s1_valid && (!s1_last || !out_valid || m_tready);
  assign s_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_phase <= 1'b0;
    end else if (cfg_wen) begin
      check_phase <= cfg_wdata;
    end
  end

  // input register: control cleared by reset, payload without reset, loaded on each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_byte <= s_tdata[7:0];
      s1_len  <= s_tdata[8 +: LEN_W];
      s1_last <= s_tlast;
    end
  end

  // field capture, sees the current byte before judging
  ohv_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_adv),
    .last        (s1_last),
    .byte_value  (s1_byte),
    .fields_next (fields_next)
  );

  // verdict on the fields including the last byte
  ohv_judge u_judge (
    .fields      (fields_next),
    .file_length (s1_len),
    .check_phase (check_phase),
    .verdict     (verdict),
    .file_size   (file_size)
  );

  // result register, loads only on a last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      out_verdict <= verdict;
      out_size    <= file_size;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_DATA_W - LEN_W - 2)'(0), out_size, out_verdict};

endmodule

`default_nettype wire

// ===== rtl/core/ohv_checker.sv =====
// port-level checker for the compound-file header validator, with its bind
`default_nettype none

`include "ole2_header_validator_core_macros.svh"

module ohv_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [ohv_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import ohv_pkg::*;

  logic [1:0]       chk_verdict;
  logic [LEN_W-1:0] chk_size;

  assign chk_verdict = m_tdata[1:0];
  assign chk_size    = m_tdata[2 +: LEN_W];

  // a stalled result holds
  `OHV_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
  // a rejected file never reports a size
  `OHV_ASSERT_SAME(a_reject_size, clk, rst, m_tvalid && chk_verdict == VERDICT_REJECT, chk_size == '0, "reject with nonzero size")
  // verified means header plus at least one whole 512-byte sector
  `OHV_ASSERT_SAME(a_verified_size, clk, rst, m_tvalid && chk_verdict == VERDICT_VERIFIED, chk_size[8:0] == 9'd0 && chk_size >= LEN_W'(1024), "verified size not sector aligned")
  // verdict code stays within its defined values
  `OHV_ASSERT_SAME(a_verdict_code, clk, rst, m_tvalid, chk_verdict == VERDICT_REJECT || chk_verdict == VERDICT_STRUCT || chk_verdict == VERDICT_VERIFIED, "undefined verdict code")

endmodule

bind ole2_header_validator_core ohv_checker u_ohv_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
